[rtl/core/cle_pkg.sv]
// Package for the cursor list engine: operation codes, status codes, FSM states
// and pool defaults. No dependencies.
package cle_pkg;

  localparam int DefPoolDepth = 256;

  typedef enum logic [3:0] {
    OP_CLEAR     = 4'd0,
    OP_FRONT     = 4'd1,
    OP_BACK      = 4'd2,
    OP_PREV      = 4'd3,
    OP_NEXT      = 4'd4,
    OP_PREPEND   = 4'd5,
    OP_APPEND    = 4'd6,
    OP_INSBEFORE = 4'd7,
    OP_INSAFTER  = 4'd8,
    OP_DELFRONT  = 4'd9,
    OP_DELBACK   = 4'd10,
    OP_DELCURSOR = 4'd11,
    OP_QUERY     = 4'd12
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOCURSOR = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_PLAN,
    S_EXEC,
    S_DONE
  } fsm_t;

endpackage

[rtl/core/cle_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cle_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/cursor_list_engine.sv]
// Top level of the cursor list engine. Uses cle_pkg and cle_ram.
// Holds the list registers, the sequencer and the node memories.
//
// Keeps a doubly linked list of signed 32-bit values in a pool of POOL_DEPTH
// nodes, with a free list and a cursor. A request (kind, value) is taken when
// start is high and busy is low. Every request gives one result, shown on the
// result ports for exactly one cycle with done high; the receiver cannot stall
// it, so it must take it in that cycle. Every request takes the same time, and
// busy stays high until done drops, so a new request is taken only after the
// previous result has been shown. The next links, the prev links and the
// values sit in three memories, each with one write and one registered read
// per cycle. The sequencer first reads the links the operation needs (the prev
// link and the free-list successor, then the next link), then plans the
// update, then writes up to two links in each link memory while the front,
// back and cursor values are read back, and shows the result last. No
// clearing pass follows reset: nodes are handed out from a fill counter until
// the pool has been used once, then from the free list. Errors (list empty,
// cursor undefined, pool full) leave the state unchanged and are reported in
// status.
module cursor_list_engine
  import cle_pkg::*;
#(
  parameter int POOL_DEPTH = DefPoolDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         kind,
  input  logic signed [31:0] value,
  output logic               done,
  output logic [1:0]         status,
  output logic [8:0]         list_length,
  output logic               cursor_valid,
  output logic [7:0]         cursor_index,
  output logic signed [31:0] front_value,
  output logic signed [31:0] back_value,
  output logic signed [31:0] cursor_value
);
  localparam int AW = $clog2(POOL_DEPTH);
  localparam int PW = AW + 1;                  // pointer with null code
  localparam logic [PW-1:0] NIL = PW'(POOL_DEPTH);

  // one planned link write
  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    logic [PW-1:0] data;
  } link_wr_t;

  function automatic link_wr_t link_wr(logic [PW-1:0] a, logic [PW-1:0] d);
    link_wr_t w;
    w.en   = 1'b1;
    w.addr = a[AW-1:0];
    w.data = d;
    return w;
  endfunction

  // list registers
  logic [PW-1:0] front, back, cur, free_head, fresh, count, cpos;
  logic [PW-1:0] front_next, back_next, cur_next, free_head_next;
  logic [PW-1:0] fresh_next, count_next, cpos_next;
  status_t       status_next;
  // per-request registers
  op_t           op;
  logic [31:0]   val;
  logic [PW-1:0] lnk_free, lnk_prv;            // next[free_head], prev[x]
  logic [1:0]    estep;
  logic [31:0]   fv, bv, cv;
  link_wr_t      nw0, nw1, pw0, pw1;
  link_wr_t      nw0_next, nw1_next, pw0_next, pw1_next;
  link_wr_t      nx_wr, pv_wr;

  fsm_t state, state_next;

  // memories
  logic [AW-1:0] nx_raddr, pv_raddr, v_raddr, v_waddr;
  logic [PW-1:0] nx_rdata, pv_rdata;
  logic          v_we;
  logic [31:0]   v_rdata;

  cle_ram #(.Width(PW), .Depth(POOL_DEPTH)) u_next (
    .clk(clk), .we(nx_wr.en), .waddr(nx_wr.addr), .wdata(nx_wr.data),
    .raddr(nx_raddr), .rdata(nx_rdata)
  );

  cle_ram #(.Width(PW), .Depth(POOL_DEPTH)) u_prev (
    .clk(clk), .we(pv_wr.en), .waddr(pv_wr.addr), .wdata(pv_wr.data),
    .raddr(pv_raddr), .rdata(pv_rdata)
  );

  cle_ram #(.Width(32), .Depth(POOL_DEPTH)) u_vals (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(val),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  logic          empty, cur_ok, have_node, is_ins, is_cur_ins, ins_ok;
  logic [PW-1:0] alloc;
  assign empty      = (count == '0);
  assign cur_ok     = (cur != NIL);
  assign have_node  = (fresh != NIL) || (free_head != NIL);
  assign is_cur_ins = (op == OP_INSBEFORE) || (op == OP_INSAFTER);
  assign is_ins     = (op == OP_PREPEND) || (op == OP_APPEND) || is_cur_ins;
  assign ins_ok     = is_ins && have_node && !(is_cur_ins && (empty || !cur_ok));
  assign alloc      = (fresh != NIL) ? fresh : free_head;

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = S_READ;
      S_READ:  state_next = S_PLAN;
      S_PLAN:  state_next = S_EXEC;
      S_EXEC:  if (estep == 2'd3) state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Reads: in idle the prev link (cursor or back) and the free-list successor,
  // in S_READ the next link (front or cursor); values during S_EXEC.
  always_comb begin
    nx_raddr = free_head[AW-1:0];
    pv_raddr = (kind == OP_DELBACK) ? back[AW-1:0] : cur[AW-1:0];
    v_raddr  = cur[AW-1:0];
    if (state == S_READ)
      nx_raddr = (op == OP_DELFRONT) ? front[AW-1:0] : cur[AW-1:0];
    if (state == S_EXEC) begin
      if (estep == 2'd0)      v_raddr = front[AW-1:0];
      else if (estep == 2'd1) v_raddr = back[AW-1:0];
    end
  end

  // new node value goes out while the list registers still hold the old state
  assign v_we    = (state == S_READ) && ins_ok;
  assign v_waddr = alloc[AW-1:0];

  // link writes: slot 0 at exec step 0, slot 1 at exec step 1
  always_comb begin
    nx_wr = '0;
    pv_wr = '0;
    if (state == S_EXEC) begin
      if (estep == 2'd0) begin
        nx_wr = nw0;
        pv_wr = pw0;
      end else if (estep == 2'd1) begin
        nx_wr = nw1;
        pv_wr = pw1;
      end
    end
  end

  // update plan, evaluated in S_PLAN
  logic [PW-1:0] del_node;
  logic          kill_front, kill_back, at_front, at_back;
  always_comb begin
    front_next     = front;
    back_next      = back;
    cur_next       = cur;
    cpos_next      = cpos;
    count_next     = count;
    free_head_next = free_head;
    fresh_next     = fresh;
    status_next    = ST_OK;
    nw0_next       = '0;
    nw1_next       = '0;
    pw0_next       = '0;
    pw1_next       = '0;
    del_node       = '0;
    kill_front     = 1'b0;
    kill_back      = 1'b0;
    at_front       = 1'b0;
    at_back        = 1'b0;
    unique case (op)
      OP_CLEAR: begin
        // splice the whole list onto the free list
        if (!empty) begin
          nw0_next       = link_wr(back, free_head);
          free_head_next = front;
        end
        front_next = NIL;
        back_next  = NIL;
        cur_next   = NIL;
        cpos_next  = '0;
        count_next = '0;
      end
      OP_FRONT: begin
        if (!empty) begin
          cur_next  = front;
          cpos_next = '0;
        end
      end
      OP_BACK: begin
        if (empty) status_next = ST_EMPTY;
        else begin
          cur_next  = back;
          cpos_next = count - 1'b1;
        end
      end
      OP_PREV: begin
        if (empty) status_next = ST_EMPTY;
        else if (cur_ok) begin
          if (cur == front) begin
            cur_next  = NIL;
            cpos_next = '0;
          end else begin
            cur_next = lnk_prv;
            if (cpos != '0) cpos_next = cpos - 1'b1;
          end
        end
      end
      OP_NEXT: begin
        if (empty) status_next = ST_EMPTY;
        else if (cur_ok) begin
          if (cur == back) begin
            cur_next  = NIL;
            cpos_next = '0;
          end else begin
            cur_next  = nx_rdata;
            cpos_next = cpos + 1'b1;
          end
        end
      end
      OP_PREPEND, OP_APPEND, OP_INSBEFORE, OP_INSAFTER: begin
        if (is_cur_ins && empty) status_next = ST_EMPTY;
        else if (is_cur_ins && !cur_ok) status_next = ST_NOCURSOR;
        else if (!have_node) status_next = ST_FULL;
        else begin
          if (fresh != NIL) fresh_next = fresh + 1'b1;
          else free_head_next = lnk_free;
          count_next = count + 1'b1;
          at_front = (op == OP_PREPEND) || (op == OP_INSBEFORE && cur == front);
          at_back  = (op == OP_APPEND) || (op == OP_INSAFTER && cur == back);
          if (empty) begin
            // first node; cursor stays undefined
            front_next = alloc;
            back_next  = alloc;
            nw0_next   = link_wr(alloc, NIL);
            pw0_next   = link_wr(alloc, NIL);
          end else if (at_front) begin
            nw0_next   = link_wr(alloc, front);
            pw0_next   = link_wr(alloc, NIL);
            pw1_next   = link_wr(front, alloc);
            front_next = alloc;
            if (cur_ok) cpos_next = cpos + 1'b1;
          end else if (at_back) begin
            pw0_next  = link_wr(alloc, back);
            nw0_next  = link_wr(alloc, NIL);
            nw1_next  = link_wr(back, alloc);
            back_next = alloc;
          end else if (op == OP_INSBEFORE) begin
            nw0_next  = link_wr(alloc, cur);
            pw0_next  = link_wr(alloc, lnk_prv);
            nw1_next  = link_wr(lnk_prv, alloc);
            pw1_next  = link_wr(cur, alloc);
            cpos_next = cpos + 1'b1;
          end else begin
            pw0_next = link_wr(alloc, cur);
            nw0_next = link_wr(alloc, nx_rdata);
            pw1_next = link_wr(nx_rdata, alloc);
            nw1_next = link_wr(cur, alloc);
          end
        end
      end
      OP_DELFRONT, OP_DELBACK, OP_DELCURSOR: begin
        if (empty) status_next = ST_EMPTY;
        else if (op == OP_DELCURSOR && !cur_ok) status_next = ST_NOCURSOR;
        else begin
          kill_back  = (op == OP_DELBACK) || (op == OP_DELCURSOR && cur == back);
          kill_front = !kill_back && ((op == OP_DELFRONT) ||
                       (op == OP_DELCURSOR && cur == front));
          del_node   = kill_back ? back : (kill_front ? front : cur);
          nw0_next       = link_wr(del_node, free_head);
          free_head_next = del_node;
          if (count == PW'(1)) begin
            front_next = NIL;
            back_next  = NIL;
            cur_next   = NIL;
            cpos_next  = '0;
            count_next = '0;
          end else begin
            count_next = count - 1'b1;
            if (kill_back) begin
              back_next = lnk_prv;
              nw1_next  = link_wr(lnk_prv, NIL);
              if (cur == del_node) begin
                cur_next  = NIL;
                cpos_next = '0;
              end
            end else if (kill_front) begin
              front_next = nx_rdata;
              pw0_next   = link_wr(nx_rdata, NIL);
              if (cur == del_node) begin
                cur_next  = NIL;
                cpos_next = '0;
              end else if (cur_ok && cpos != '0) begin
                cpos_next = cpos - 1'b1;
              end
            end else begin
              // middle node under the cursor
              nw1_next  = link_wr(lnk_prv, nx_rdata);
              pw0_next  = link_wr(nx_rdata, lnk_prv);
              cur_next  = NIL;
              cpos_next = '0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // list registers change only at the end of S_PLAN
  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= NIL;
      back      <= NIL;
      cur       <= NIL;
      free_head <= NIL;
      fresh     <= '0;
      count     <= '0;
      cpos      <= '0;
      status    <= ST_OK;
    end else if (state == S_PLAN) begin
      front     <= front_next;
      back      <= back_next;
      cur       <= cur_next;
      free_head <= free_head_next;
      fresh     <= fresh_next;
      count     <= count_next;
      cpos      <= cpos_next;
      status    <= status_next;
    end
  end

  // request capture, link capture, write plan and value readback
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op  <= op_t'(kind);
      val <= value;
    end
    if (state == S_READ) begin
      lnk_free <= nx_rdata;
      lnk_prv  <= pv_rdata;
    end
    if (state == S_PLAN) begin
      nw0   <= nw0_next;
      nw1   <= nw1_next;
      pw0   <= pw0_next;
      pw1   <= pw1_next;
      estep <= '0;
    end else if (state == S_EXEC) begin
      estep <= estep + 1'b1;
    end
    if (state == S_EXEC) begin
      if (estep == 2'd1) fv <= v_rdata;
      if (estep == 2'd2) bv <= v_rdata;
      if (estep == 2'd3) cv <= v_rdata;
    end
  end

  // result outputs, stable during the done cycle
  assign list_length  = 9'(count);
  assign cursor_valid = cur_ok;
  assign cursor_index = cur_ok ? 8'(cpos) : 8'd0;
  assign front_value  = empty ? 32'sd0 : $signed(fv);
  assign back_value   = empty ? 32'sd0 : $signed(bv);
  assign cursor_value = cur_ok ? $signed(cv) : 32'sd0;
endmodule
